// File: src/dfd_pkg.sv
`default_nettype none

package dfd_pkg;

  // Frame layout defaults.
  localparam int unsigned DefPreambleLen = 4;
  localparam int unsigned DefHeaderLen   = 8;

  // Framing marks and the fixed postamble length.
  localparam logic [7:0] MarkPre  = 8'h7E;
  localparam logic [7:0] MarkPost = 8'h6E;
  localparam logic [9:0] PostLen  = 10'd4;

  // Register reset values.
  localparam logic [9:0]  HuntTimeoutRst = 10'd500;
  localparam logic [10:0] GapTimeoutRst  = 11'd500;

  // Configuration register indexes.
  localparam logic RegHuntTimeout = 1'b0;
  localparam logic RegGapTimeout  = 1'b1;

  // Request types.
  localparam logic ReqByte = 1'b0;
  localparam logic ReqTick = 1'b1;

  // Result kinds.
  localparam logic [1:0] KindHeader  = 2'd0;
  localparam logic [1:0] KindContent = 2'd1;
  localparam logic [1:0] KindStatus  = 2'd2;

  // Frame end status codes.
  localparam logic [2:0] StOk           = 3'd0;
  localparam logic [2:0] StHuntTimeout  = 3'd1;
  localparam logic [2:0] StShortHeader  = 3'd2;
  localparam logic [2:0] StShortContent = 3'd3;
  localparam logic [2:0] StShortPost    = 3'd4;
  localparam logic [2:0] StBadPost      = 3'd5;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } dfd_in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [10:0] byte_index;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [9:0]  expected_count;
    logic [9:0]  received_count;
  } dfd_out_t;

endpackage

`default_nettype wire

// File: src/diag_frame_deframer_top.sv
`default_nettype none

// Deframer for a diagnostic byte stream. Each request is either a received byte or
// one 2 ms tick. The block hunts for PREAMBLE_LEN consecutive 0x7E bytes, then passes
// on HEADER_LEN header bytes and, with header byte 0 times four as the length, the
// content bytes, each as one result. Four postamble bytes end the frame with one
// status result (ok or bad postamble). Too many ticks while hunting give a hunt
// timeout; a run of idle ticks after the preamble gives a short-read status. After
// every status the block hunts again. A request is taken in every cycle and its
// result, if any, appears in the output register on the next cycle; the only limit
// is that output register, which stalls input while a result waits to be taken.
// The configuration port is always ready.
module diag_frame_deframer_top #(
  parameter int unsigned PREAMBLE_LEN = dfd_pkg::DefPreambleLen,
  parameter int unsigned HEADER_LEN   = dfd_pkg::DefHeaderLen
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire dfd_pkg::dfd_in_t in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      dfd_pkg::dfd_out_t out_data_o,
  input  wire logic             cfg_valid_i,
  output      logic             cfg_ready_o,
  input  wire logic             cfg_index_i,
  input  wire logic [10:0]      cfg_data_i
);
  import dfd_pkg::*;

  typedef enum logic [1:0] {
    PhHunt,
    PhHead,
    PhBody,
    PhPost
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  pre_run_q, pre_run_d;
  logic [9:0]  hunt_ticks_q, hunt_ticks_d;
  logic [10:0] gap_ticks_q, gap_ticks_d;
  logic [9:0]  count_q, count_d;
  logic [9:0]  content_len_q, content_len_d;
  logic        post_good_q, post_good_d;
  logic [9:0]  hunt_timeout_q;
  logic [10:0] gap_timeout_q;
  logic        out_valid_q;
  dfd_out_t    out_q;

  logic        in_fire;
  logic        res_valid;
  dfd_out_t    res;
  logic [10:0] hunt_next;
  logic [11:0] gap_next;
  logic [9:0]  count_inc;
  logic [2:0]  pre_inc;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign hunt_next = {1'b0, hunt_ticks_q} + 11'd1;
  assign gap_next  = {1'b0, gap_ticks_q} + 12'd1;
  assign count_inc = count_q + 10'd1;
  assign pre_inc   = pre_run_q + 3'd1;

  // Next state and result for one request.
  always_comb begin
    phase_d       = phase_q;
    pre_run_d     = pre_run_q;
    hunt_ticks_d  = hunt_ticks_q;
    gap_ticks_d   = gap_ticks_q;
    count_d       = count_q;
    content_len_d = content_len_q;
    post_good_d   = post_good_q;
    res_valid     = 1'b0;
    res           = '0;

    if (in_data_i.req_type == ReqTick) begin
      if (phase_q == PhHunt) begin
        if (hunt_next > {1'b0, hunt_timeout_q}) begin
          res_valid          = 1'b1;
          res.out_kind       = KindStatus;
          res.status         = StHuntTimeout;
          res.expected_count = 10'(PREAMBLE_LEN);
          res.received_count = {7'd0, pre_run_q};
        end else begin
          hunt_ticks_d = hunt_next[9:0];
        end
      end else if (gap_next > {1'b0, gap_timeout_q}) begin
        res_valid          = 1'b1;
        res.out_kind       = KindStatus;
        res.received_count = count_q;
        case (phase_q)
          PhHead: begin
            res.status         = StShortHeader;
            res.expected_count = 10'(HEADER_LEN);
          end
          PhBody: begin
            res.status         = StShortContent;
            res.expected_count = content_len_q;
          end
          default: begin
            res.status         = StShortPost;
            res.expected_count = PostLen;
          end
        endcase
      end else begin
        gap_ticks_d = gap_next[10:0];
      end
    end else begin
      case (phase_q)
        PhHunt: begin
          if (in_data_i.rx_byte == MarkPre) begin
            pre_run_d = pre_inc;
            if (pre_inc >= 3'(PREAMBLE_LEN)) begin
              phase_d     = PhHead;
              count_d     = '0;
              gap_ticks_d = '0;
            end
          end else begin
            pre_run_d = '0;
          end
        end
        PhHead: begin
          gap_ticks_d    = '0;
          res_valid      = 1'b1;
          res.out_kind   = KindHeader;
          res.byte_index = {1'b0, count_q};
          res.data_byte  = in_data_i.rx_byte;
          if (count_q == '0) begin
            content_len_d = {in_data_i.rx_byte, 2'b00};
          end
          count_d = count_inc;
          if (count_inc >= 10'(HEADER_LEN)) begin
            count_d = '0;
            phase_d = (content_len_d == '0) ? PhPost : PhBody;
          end
        end
        PhBody: begin
          gap_ticks_d    = '0;
          res_valid      = 1'b1;
          res.out_kind   = KindContent;
          res.byte_index = 11'(HEADER_LEN) + {1'b0, count_q};
          res.data_byte  = in_data_i.rx_byte;
          count_d        = count_inc;
          if (count_inc >= content_len_q) begin
            count_d = '0;
            phase_d = PhPost;
          end
        end
        default: begin
          gap_ticks_d = '0;
          if (in_data_i.rx_byte != MarkPost) begin
            post_good_d = 1'b0;
          end
          count_d = count_inc;
          if (count_inc >= PostLen) begin
            res_valid          = 1'b1;
            res.out_kind       = KindStatus;
            res.status         = (post_good_d) ? StOk : StBadPost;
            res.expected_count = PostLen;
            res.received_count = PostLen;
          end
        end
      endcase
    end

    // Every frame end returns to the hunt with cleared counters.
    if (res_valid && res.out_kind == KindStatus) begin
      phase_d       = PhHunt;
      pre_run_d     = '0;
      hunt_ticks_d  = '0;
      gap_ticks_d   = '0;
      count_d       = '0;
      content_len_d = '0;
      post_good_d   = 1'b1;
    end
  end

  // State, registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhHunt;
      pre_run_q      <= '0;
      hunt_ticks_q   <= '0;
      gap_ticks_q    <= '0;
      count_q        <= '0;
      content_len_q  <= '0;
      post_good_q    <= 1'b1;
      hunt_timeout_q <= HuntTimeoutRst;
      gap_timeout_q  <= GapTimeoutRst;
      out_valid_q    <= 1'b0;
      out_q          <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == RegHuntTimeout) begin
          hunt_timeout_q <= cfg_data_i[9:0];
        end else begin
          gap_timeout_q <= cfg_data_i;
        end
      end
      if (in_fire) begin
        phase_q       <= phase_d;
        pre_run_q     <= pre_run_d;
        hunt_ticks_q  <= hunt_ticks_d;
        gap_ticks_q   <= gap_ticks_d;
        count_q       <= count_d;
        content_len_q <= content_len_d;
        post_good_q   <= post_good_d;
        out_valid_q   <= res_valid;
        if (res_valid) begin
          out_q <= res;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A status result always sends the block back to the hunt.
  a_status_to_hunt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_valid && res.out_kind == KindStatus |=> phase_q == PhHunt)
    else $error("status result did not return to hunt");

  // Header results stay inside the header.
  a_header_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.out_kind == KindHeader |-> out_q.byte_index < 11'(HEADER_LEN))
    else $error("header byte index out of range");

  // Content results follow the header.
  a_content_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.out_kind == KindContent |-> out_q.byte_index >= 11'(HEADER_LEN))
    else $error("content byte index inside header");

  // The content phase is entered only with a nonzero length.
  a_body_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhBody |-> content_len_q != '0 && count_q < content_len_q)
    else $error("content phase with bad length or count");

  // Within the header the count stays below the header length.
  a_head_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHead |-> count_q < 10'(HEADER_LEN))
    else $error("header count out of range");

endmodule

`default_nettype wire
